>>> rtl/ppas_pkg.sv
// Shared types and constants for the per-CPU page allocator with stealing.
`default_nettype none

package ppas_pkg;

	localparam int ADDR_W    = 32;
	localparam int CPU_IN_W  = 3;
	localparam int KIND_W    = 1;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	localparam int DEF_NUM_CPUS    = 8;
	localparam int DEF_NUM_PAGES   = 32768;
	localparam int DEF_STEAL_COUNT = 32;
	localparam int DEF_PAGE_SHIFT  = 12;

	localparam logic [ADDR_W-1:0] MEM_START_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 32'h8800_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_FREE  = 1'b0,
		KIND_ALLOC = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OOM      = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEM_START = 1'b0,
		CFG_MEM_STOP  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_F_CHECK,
		S_F_PUSH,
		S_A_HEAD,
		S_A_POP,
		S_A_SCAN,
		S_A_WALK,
		S_A_RD1,
		S_A_RD2,
		S_RESP
	} state_t;

	typedef enum logic {
		AU_SLOT_OFS,
		AU_PAGE_ADDR
	} au_op_t;

	typedef struct packed {
		au_op_t              op;
		logic [ADDR_W-1:0]   base;
		logic [ADDR_W-1:0]   operand;
	} au_req_t;

endpackage

`default_nettype wire

>>> rtl/ppas_req_if.sv
// Request channel: free or allocate a page.
`default_nettype none

interface ppas_req_if;
	logic                          valid;
	logic                          ready;
	logic [ppas_pkg::KIND_W-1:0]   kind;
	logic [ppas_pkg::CPU_IN_W-1:0] cpu;
	logic [ppas_pkg::ADDR_W-1:0]   address;

	modport source(output valid, kind, cpu, address, input ready);
	modport sink(input valid, kind, cpu, address, output ready);
endinterface

`default_nettype wire

>>> rtl/ppas_rsp_if.sv
// Response channel: allocated page address and status.
`default_nettype none

interface ppas_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ppas_pkg::ADDR_W-1:0]   page_address;
	logic [ppas_pkg::STATUS_W-1:0] status;

	modport source(output valid, page_address, status, input ready);
	modport sink(input valid, page_address, status, output ready);
endinterface

`default_nettype wire

>>> rtl/ppas_addr_unit.sv
// Shared adder: address to slot offset, or slot to page address.
`default_nettype none

module ppas_addr_unit #(
	parameter int PAGE_SHIFT = ppas_pkg::DEF_PAGE_SHIFT
) (
	input  ppas_pkg::au_req_t              req,
	output logic [ppas_pkg::ADDR_W-1:0]    result
);

	logic [ppas_pkg::ADDR_W-1:0] opa;
	logic [ppas_pkg::ADDR_W-1:0] opb;
	logic [ppas_pkg::ADDR_W-1:0] sum;
	logic                        sub;

	// operand - base is operand + ~base + 1
	always_comb begin
		sub = (req.op == ppas_pkg::AU_SLOT_OFS);
		opa = sub ? req.operand : req.base;
		opb = sub ? ~req.base : (req.operand << PAGE_SHIFT);
		sum = opa + opb + ppas_pkg::ADDR_W'(sub);
		result = sub ? (sum >> PAGE_SHIFT) : sum;
	end

endmodule

`default_nettype wire

>>> rtl/percpu_page_allocator_steal_core.sv
// Per-CPU LIFO page allocator: a request frees or allocates one page, one response per request.
// req carries kind, cpu and address; rsp returns page_address and status (ok, out of memory,
// bad free address). mem_start and mem_stop must be written through wr_en/wr_index/wr_data
// only while idle, which the block itself does not enforce. One request is worked at a time;
// req.ready is high only while the sequencer is idle. Free steps through check, push, respond;
// a local pop steps through head, pop, respond. A steal steps through head, a scan of up to
// NUM_CPUS-1 donors, a walk over a batch of up to STEAL_COUNT pages, RD1, RD2 and respond; the walk
// is bound by the single read port of the link memory, one link per cycle. Responses are
// registered. If rsp is stalled, a finished result waits in the respond state and req stays low.
// Reset clears all heads to empty; the link memory needs no clearing since every link
// read was written by an earlier free.
`default_nettype none

module percpu_page_allocator_steal_core #(
	parameter int NUM_CPUS    = ppas_pkg::DEF_NUM_CPUS,
	parameter int NUM_PAGES   = ppas_pkg::DEF_NUM_PAGES,
	parameter int STEAL_COUNT = ppas_pkg::DEF_STEAL_COUNT,
	parameter int PAGE_SHIFT  = ppas_pkg::DEF_PAGE_SHIFT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ppas_req_if.sink                            req,
	ppas_rsp_if.source                          rsp,
	input  wire logic                           wr_en,
	input  wire logic [ppas_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [ppas_pkg::CFG_W-1:0]     wr_data
);

	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int SLOT_W = $clog2(NUM_PAGES + 1);
	localparam int IDX_W  = $clog2(NUM_PAGES);
	localparam int STL_W  = $clog2(STEAL_COUNT + 1);
	localparam int AW     = ppas_pkg::ADDR_W;

	localparam logic [SLOT_W-1:0] NIL      = SLOT_W'(NUM_PAGES);
	localparam logic [CPU_W-1:0]  LAST_CPU = CPU_W'(NUM_CPUS - 1);
	localparam logic [STL_W-1:0]  STEAL_N  = STL_W'(STEAL_COUNT);
	localparam logic [AW-1:0]     PAGE_MASK = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [AW-1:0]     BASE_RST =
		(ppas_pkg::MEM_START_RST + PAGE_MASK) & ~PAGE_MASK;

	function automatic logic [CPU_W-1:0] cpu_mod(input logic [ppas_pkg::CPU_IN_W-1:0] c);
		logic [7:0] v;
		v = 8'(c);
		for (int k = 0; k < 8; k++) begin
			if (v >= 8'(NUM_CPUS))
				v = v - 8'(NUM_CPUS);
		end
		return CPU_W'(v);
	endfunction

	function automatic logic [CPU_W-1:0] cpu_next(input logic [CPU_W-1:0] c);
		return (c == LAST_CPU) ? '0 : c + 1'b1;
	endfunction

	// configuration
	logic [AW-1:0] mem_start_q;
	logic [AW-1:0] mem_stop_q;
	logic [AW-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_start_q <= ppas_pkg::MEM_START_RST;
			mem_stop_q  <= ppas_pkg::MEM_STOP_RST;
			base_q      <= BASE_RST;
		end else if (wr_en) begin
			unique case (ppas_pkg::cfg_reg_t'(wr_index))
				ppas_pkg::CFG_MEM_START: begin
					mem_start_q <= wr_data;
					base_q      <= (wr_data + PAGE_MASK) & ~PAGE_MASK;
				end
				ppas_pkg::CFG_MEM_STOP: mem_stop_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer and datapath registers
	ppas_pkg::state_t  state_q, state_d;
	logic [CPU_W-1:0]  cpu_q;
	logic [AW-1:0]     addr_q;
	logic [CPU_W-1:0]  donor_q;
	logic [CPU_W-1:0]  scan_q;
	logic [STL_W-1:0]  walk_n_q;
	logic [SLOT_W-1:0] first_q;
	logic [SLOT_W-1:0] tail_q;
	logic [AW-1:0]     ofs_q;
	logic              ok_q;
	logic [AW-1:0]     res_page_q;
	ppas_pkg::status_t res_status_q;

	logic              rsp_valid_q;
	logic [AW-1:0]     rsp_page_q;
	ppas_pkg::status_t rsp_status_q;

	// list heads: reset to empty, one read and one write index per cycle
	logic [SLOT_W-1:0] head_q [NUM_CPUS];
	logic [CPU_W-1:0]  hd_ridx;
	logic [SLOT_W-1:0] hd_rdata;
	logic              hd_we;
	logic [CPU_W-1:0]  hd_widx;
	logic [SLOT_W-1:0] hd_wdata;

	// link memory
	logic [SLOT_W-1:0] link_mem [NUM_PAGES];
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [SLOT_W-1:0] mem_wdata;
	logic [SLOT_W-1:0] rdata_q;

	ppas_pkg::au_req_t au_req;
	logic [AW-1:0]     au_res;

	logic head_hit;
	logic walk_more;
	logic slot_ok;
	logic out_free;

	ppas_addr_unit #(
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_addr_unit (
		.req    (au_req),
		.result (au_res)
	);

	assign hd_rdata  = head_q[hd_ridx];
	assign head_hit  = (hd_rdata < NIL);
	assign walk_more = (walk_n_q < STEAL_N) && (rdata_q < NIL);
	assign slot_ok   = ok_q && (ofs_q < AW'(NUM_PAGES));
	assign out_free  = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ppas_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		hd_ridx        = cpu_q;
		hd_we          = 1'b0;
		hd_widx        = cpu_q;
		hd_wdata       = rdata_q;
		mem_re         = 1'b0;
		mem_raddr      = hd_rdata[IDX_W-1:0];
		mem_we         = 1'b0;
		mem_waddr      = tail_q[IDX_W-1:0];
		mem_wdata      = NIL;
		au_req.op      = ppas_pkg::AU_PAGE_ADDR;
		au_req.base    = base_q;
		au_req.operand = AW'(first_q);
		unique case (state_q)
			ppas_pkg::S_IDLE: begin
				if (req.valid)
					state_d = (req.kind == ppas_pkg::KIND_ALLOC) ?
						ppas_pkg::S_A_HEAD : ppas_pkg::S_F_CHECK;
			end
			ppas_pkg::S_F_CHECK: begin
				au_req.op      = ppas_pkg::AU_SLOT_OFS;
				au_req.operand = addr_q;
				state_d        = ppas_pkg::S_F_PUSH;
			end
			ppas_pkg::S_F_PUSH: begin
				if (slot_ok) begin
					hd_we     = 1'b1;
					hd_wdata  = ofs_q[SLOT_W-1:0];
					mem_we    = 1'b1;
					mem_waddr = ofs_q[IDX_W-1:0];
					mem_wdata = hd_rdata;
				end
				state_d = ppas_pkg::S_RESP;
			end
			ppas_pkg::S_A_HEAD: begin
				if (head_hit) begin
					mem_re  = 1'b1;
					state_d = ppas_pkg::S_A_POP;
				end else if (NUM_CPUS == 1) begin
					state_d = ppas_pkg::S_RESP;
				end else begin
					state_d = ppas_pkg::S_A_SCAN;
				end
			end
			ppas_pkg::S_A_POP: begin
				hd_we   = 1'b1;
				state_d = ppas_pkg::S_RESP;
			end
			ppas_pkg::S_A_SCAN: begin
				hd_ridx = donor_q;
				if (head_hit) begin
					mem_re  = 1'b1;
					state_d = ppas_pkg::S_A_WALK;
				end else if (scan_q == LAST_CPU) begin
					state_d = ppas_pkg::S_RESP;
				end
			end
			ppas_pkg::S_A_WALK: begin
				if (walk_more) begin
					mem_re    = 1'b1;
					mem_raddr = rdata_q[IDX_W-1:0];
				end else begin
					// cut the batch: donor keeps what follows the tail
					hd_we   = 1'b1;
					hd_widx = donor_q;
					mem_we  = 1'b1;
					state_d = ppas_pkg::S_A_RD1;
				end
			end
			ppas_pkg::S_A_RD1: begin
				mem_re    = 1'b1;
				mem_raddr = first_q[IDX_W-1:0];
				state_d   = ppas_pkg::S_A_RD2;
			end
			ppas_pkg::S_A_RD2: begin
				hd_we     = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = first_q[IDX_W-1:0];
				state_d   = ppas_pkg::S_RESP;
			end
			ppas_pkg::S_RESP: begin
				if (out_free)
					state_d = ppas_pkg::S_IDLE;
			end
			default: state_d = ppas_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ppas_pkg::S_IDLE: begin
				if (req.valid) begin
					cpu_q        <= cpu_mod(req.cpu);
					addr_q       <= req.address;
					res_page_q   <= '0;
					res_status_q <= ppas_pkg::ST_OK;
				end
			end
			ppas_pkg::S_F_CHECK: begin
				ok_q  <= (addr_q[PAGE_SHIFT-1:0] == '0) && (addr_q >= mem_start_q) &&
					(addr_q < mem_stop_q);
				ofs_q <= au_res;
			end
			ppas_pkg::S_F_PUSH: begin
				if (!slot_ok)
					res_status_q <= ppas_pkg::ST_BAD_ADDR;
			end
			ppas_pkg::S_A_HEAD: begin
				first_q <= hd_rdata;
				if (!head_hit) begin
					res_status_q <= ppas_pkg::ST_OOM;
					donor_q      <= cpu_next(cpu_q);
					scan_q       <= CPU_W'(1);
				end
			end
			ppas_pkg::S_A_POP: res_page_q <= au_res;
			ppas_pkg::S_A_SCAN: begin
				if (head_hit) begin
					first_q  <= hd_rdata;
					tail_q   <= hd_rdata;
					walk_n_q <= STL_W'(1);
				end else begin
					donor_q <= cpu_next(donor_q);
					scan_q  <= scan_q + 1'b1;
				end
			end
			ppas_pkg::S_A_WALK: begin
				if (walk_more) begin
					tail_q   <= rdata_q;
					walk_n_q <= walk_n_q + 1'b1;
				end
			end
			ppas_pkg::S_A_RD2: begin
				res_page_q   <= au_res;
				res_status_q <= ppas_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++)
				head_q[i] <= NIL;
		end else if (hd_we) begin
			head_q[hd_widx] <= hd_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			link_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= link_mem[mem_raddr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == ppas_pkg::S_RESP && out_free)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ppas_pkg::S_RESP && out_free) begin
			rsp_page_q   <= res_page_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign req.ready        = (state_q == ppas_pkg::S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.page_address = rsp_page_q;
	assign rsp.status       = rsp_status_q;

	a_link_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_waddr} < (IDX_W + 1)'(NUM_PAGES)))
		else $error("link write outside page range");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppas_pkg::S_A_WALK |-> (walk_n_q != '0) && (walk_n_q <= STEAL_N))
		else $error("steal walk count out of bounds");

	a_alloc_starts_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.kind == ppas_pkg::KIND_ALLOC
		|=> state_q == ppas_pkg::S_A_HEAD)
		else $error("allocate did not start with own head");

	a_donor_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppas_pkg::S_A_SCAN |-> donor_q != cpu_q)
		else $error("donor scan reached requesting cpu");

	a_fail_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ppas_pkg::ST_OK |-> rsp.page_address == '0)
		else $error("failed request returned a page");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the per-CPU page allocator with stealing.
`default_nettype none

module tb;

	localparam int NUM_CPUS    = ppas_pkg::DEF_NUM_CPUS;
	localparam int NUM_PAGES   = ppas_pkg::DEF_NUM_PAGES;
	localparam int STEAL_COUNT = ppas_pkg::DEF_STEAL_COUNT;
	localparam int PAGE_SHIFT  = ppas_pkg::DEF_PAGE_SHIFT;
	localparam int PAGE_SIZE   = 1 << PAGE_SHIFT;
	localparam logic [31:0] PAGE_MASK = 32'(PAGE_SIZE - 1);
	localparam logic [15:0] NIL_SLOT  = 16'(NUM_PAGES);

	typedef struct {
		logic [ppas_pkg::ADDR_W-1:0] page;
		ppas_pkg::status_t           status;
	} grant_t;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [ppas_pkg::CFG_IDX_W-1:0] wr_index;
	logic [ppas_pkg::CFG_W-1:0]     wr_data;

	ppas_req_if req();
	ppas_rsp_if rsp();

	percpu_page_allocator_steal_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// shadow of the allocator state
	logic [15:0] link_mem [NUM_PAGES];
	logic [15:0] head_of [NUM_CPUS];
	logic [31:0] cfg_start;
	logic [31:0] cfg_stop;

	grant_t      pending_grants[$];
	logic [31:0] granted_pages[$];

	int unsigned mismatches;
	int unsigned ready_hold;
	bit          steady;
	bit          req_up;
	int unsigned cnt_free_ok, cnt_bad, cnt_local, cnt_steal, cnt_oom;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [32:0] page_base();
		return ({1'b0, cfg_start} + 33'(PAGE_SIZE - 1)) & ~33'(PAGE_SIZE - 1);
	endfunction

	function automatic logic [31:0] slot_addr(int unsigned slot);
		logic [32:0] a;
		a = page_base() + (33'(slot) << PAGE_SHIFT);
		return a[31:0];
	endfunction

	function automatic int unsigned usable_pages();
		logic [32:0] b;
		logic [32:0] span;
		b = page_base();
		if (b >= {1'b0, cfg_stop})
			return 0;
		span = ({1'b0, cfg_stop} - b + 33'(PAGE_SIZE - 1)) >> PAGE_SHIFT;
		return (span > NUM_PAGES) ? NUM_PAGES : int'(span);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void predict_grant(input ppas_pkg::kind_t k, input logic [2:0] c,
			input logic [31:0] a, output grant_t g);
		int unsigned cpu_i, donor;
		logic [32:0] slot;
		logic [15:0] r, tail;
		int unsigned n;
		bit ok, found;
		cpu_i = c % NUM_CPUS;
		g.page = '0;
		g.status = ppas_pkg::ST_OK;
		if (k == ppas_pkg::KIND_FREE) begin
			ok = (a & PAGE_MASK) == 0 && a >= cfg_start && a < cfg_stop;
			slot = '0;
			if (ok) begin
				slot = ({1'b0, a} - page_base()) >> PAGE_SHIFT;
				ok = slot < NUM_PAGES;
			end
			if (ok) begin
				link_mem[slot[15:0]] = head_of[cpu_i];
				head_of[cpu_i] = slot[15:0];
				cnt_free_ok++;
			end else begin
				g.status = ppas_pkg::ST_BAD_ADDR;
				cnt_bad++;
			end
		end else begin
			r = head_of[cpu_i];
			if (r != NIL_SLOT) begin
				head_of[cpu_i] = link_mem[r];
				g.page = slot_addr(r);
				cnt_local++;
			end else begin
				found = 1'b0;
				for (int unsigned i = 1; i < NUM_CPUS && !found; i++) begin
					donor = (cpu_i + i) % NUM_CPUS;
					r = head_of[donor];
					if (r != NIL_SLOT) begin
						found = 1'b1;
						tail = r;
						n = 1;
						while (n < STEAL_COUNT && link_mem[tail] != NIL_SLOT) begin
							tail = link_mem[tail];
							n++;
						end
						// detach the batch, then the rest becomes the requester's list
						head_of[donor] = link_mem[tail];
						link_mem[tail] = NIL_SLOT;
						head_of[cpu_i] = link_mem[r];
						link_mem[r] = NIL_SLOT;
						g.page = slot_addr(r);
					end
				end
				if (found) begin
					cnt_steal++;
				end else begin
					g.status = ppas_pkg::ST_OOM;
					cnt_oom++;
				end
			end
		end
	endfunction

	task automatic send_request(ppas_pkg::kind_t k, logic [2:0] c, logic [31:0] a);
		int unsigned gap;
		grant_t g;
		gap = pick_gap();
		if (gap != 0 && req_up) begin
			req.valid <= 1'b0;
			req_up = 1'b0;
		end
		repeat (gap) @(posedge clk);
		req.valid   <= 1'b1;
		req.kind    <= k;
		req.cpu     <= c;
		req.address <= a;
		req_up = 1'b1;
		do @(posedge clk); while (!req.ready);
		predict_grant(k, c, a, g);
		pending_grants.push_back(g);
		if (k == ppas_pkg::KIND_ALLOC && g.status == ppas_pkg::ST_OK &&
				granted_pages.size() < 512)
			granted_pages.push_back(g.page);
	endtask

	task automatic wait_idle();
		if (req_up) begin
			req.valid <= 1'b0;
			req_up = 1'b0;
			@(posedge clk);
		end
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic set_window(logic [31:0] start_addr, logic [31:0] stop_addr);
		wait_idle();
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= ppas_pkg::CFG_MEM_START;
		wr_data  <= start_addr;
		@(posedge clk);
		wr_index <= ppas_pkg::CFG_MEM_STOP;
		wr_data  <= stop_addr;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_start = start_addr;
		cfg_stop  = stop_addr;
		granted_pages.delete();
	endtask

	// response side: random backpressure and comparison against the oldest prediction
	always @(posedge clk) begin : rsp_check
		grant_t g;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_grants.size() == 0) begin
					$display("%0t: unexpected response: page_address %h status %0d",
						$time, rsp.page_address, rsp.status);
					mismatches++;
				end else begin
					g = pending_grants.pop_front();
					if (rsp.page_address !== g.page) begin
						$display("%0t: page_address expected %h got %h",
							$time, g.page, rsp.page_address);
						mismatches++;
					end
					if (rsp.status !== g.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, g.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (ready_hold != 0) begin
				ready_hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				ready_hold = pick_gap();
			end
		end
	end

	task automatic test_bounds_at_reset();
		send_request(ppas_pkg::KIND_ALLOC, 3'd0, 32'h0);            // nothing free yet
		send_request(ppas_pkg::KIND_FREE, 3'd0, 32'h8000_0000);     // lowest page
		send_request(ppas_pkg::KIND_FREE, 3'd7, 32'h87FF_F000);     // highest page
		send_request(ppas_pkg::KIND_FREE, 3'd3, 32'h8800_0000);     // at mem_stop
		send_request(ppas_pkg::KIND_FREE, 3'd3, 32'h7FFF_F000);     // below mem_start
		send_request(ppas_pkg::KIND_FREE, 3'd3, 32'h8000_0800);     // misaligned
		send_request(ppas_pkg::KIND_FREE, 3'd3, 32'hFFFF_FFFF);
	endtask

	task automatic test_double_free_and_steal();
		// the same page twice makes a self-linked list; steal walk must stop at the batch limit
		send_request(ppas_pkg::KIND_FREE, 3'd0, 32'h8000_1000);
		send_request(ppas_pkg::KIND_FREE, 3'd0, 32'h8000_1000);
		send_request(ppas_pkg::KIND_ALLOC, 3'd0, 32'hFFFF_FFFF);
		send_request(ppas_pkg::KIND_ALLOC, 3'd0, 32'h0);
		send_request(ppas_pkg::KIND_ALLOC, 3'd5, 32'h0);            // steals from cpu 7
		send_request(ppas_pkg::KIND_ALLOC, 3'd6, 32'h0);            // wraps around to cpu 0
		send_request(ppas_pkg::KIND_ALLOC, 3'd0, 32'h0);
		send_request(ppas_pkg::KIND_ALLOC, 3'd0, 32'h0);
	endtask

	task automatic test_window_extremes();
		set_window(32'h0000_0801, 32'hFFFF_FFFF);                   // base rounds up to 0x1000
		send_request(ppas_pkg::KIND_FREE, 3'd1, 32'h0000_0000);
		send_request(ppas_pkg::KIND_FREE, 3'd1, 32'h0000_1000);
		send_request(ppas_pkg::KIND_FREE, 3'd2, 32'h0800_0000);     // last slot
		send_request(ppas_pkg::KIND_FREE, 3'd2, 32'h0800_1000);     // one past the last slot
		set_window(32'hFFFF_FFFF, 32'h0000_0000);                   // base wraps past 2^32
		send_request(ppas_pkg::KIND_FREE, 3'd4, 32'hFFFF_F000);
		send_request(ppas_pkg::KIND_ALLOC, 3'd1, 32'h0);
		send_request(ppas_pkg::KIND_ALLOC, 3'd4, 32'h0);
	endtask

	task automatic run_traffic(int unsigned count);
		int unsigned hot, free_pct, n_usable, idx, win;
		logic [2:0] c;
		logic [31:0] a;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				hot = $urandom_range(0, NUM_CPUS - 1);
				case ($urandom_range(0, 2))
					0: free_pct = 30;
					1: free_pct = 50;
					default: free_pct = 75;
				endcase
				steady = ($urandom_range(0, 3) == 0);
			end
			n_usable = usable_pages();
			a = $urandom();
			if ($urandom_range(0, 99) < free_pct) begin
				// frees mostly land on one cpu so the others have to steal
				c = ($urandom_range(0, 99) < 70) ? 3'(hot) : 3'($urandom_range(0, 7));
				idx = $urandom_range(0, 99);
				if (idx < 40 && granted_pages.size() != 0) begin
					idx = $urandom_range(0, granted_pages.size() - 1);
					a = granted_pages[idx];
					granted_pages.delete(idx);
				end else if (idx < 85 && n_usable != 0) begin
					win = (n_usable < 256) ? n_usable : 256;
					if ($urandom_range(0, 3) == 0)
						a = slot_addr($urandom_range(0, n_usable - 1));
					else
						a = slot_addr($urandom_range(0, win - 1));
				end else begin
					case ($urandom_range(0, 4))
						0: a = slot_addr($urandom_range(0, 63)) | $urandom_range(1, PAGE_SIZE - 1);
						1: a = (cfg_start - $urandom_range(1, 1 << 20)) & ~PAGE_MASK;
						2: a = ((cfg_stop + PAGE_MASK) & ~PAGE_MASK) +
							($urandom_range(0, 15) << PAGE_SHIFT);
						3: a = slot_addr(NUM_PAGES + $urandom_range(0, 15));
						default: ;
					endcase
				end
				send_request(ppas_pkg::KIND_FREE, c, a);
			end else begin
				send_request(ppas_pkg::KIND_ALLOC, 3'($urandom_range(0, 7)), a);
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		logic [31:0] s;
		set_window(ppas_pkg::MEM_START_RST, ppas_pkg::MEM_STOP_RST);
		run_traffic(500);
		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		run_traffic(400);
		set_window(32'hFFFF_FFFF, 32'h0000_0000);
		run_traffic(40);
		repeat (3) begin
			s = $urandom();
			set_window(s, s + ($urandom_range(1, 40000) << PAGE_SHIFT) + $urandom_range(0, 4095));
			run_traffic(300);
		end
		// tiny window: lists run dry and pages get freed twice
		s = $urandom();
		set_window(s, s + (16 << PAGE_SHIFT));
		run_traffic(160);
	endtask

	initial begin
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.kind    = ppas_pkg::KIND_FREE;
		req.cpu     = '0;
		req.address = '0;
		wr_en       = 1'b0;
		wr_index    = ppas_pkg::CFG_MEM_START;
		wr_data     = '0;
		cfg_start   = ppas_pkg::MEM_START_RST;
		cfg_stop    = ppas_pkg::MEM_STOP_RST;
		for (int i = 0; i < NUM_CPUS; i++)
			head_of[i] = NIL_SLOT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bounds_at_reset();
		test_double_free_and_steal();
		test_window_extremes();
		test_random_traffic();

		wait_idle();
		repeat (60) @(posedge clk);
		$display("Ran %0d page frees and %0d rejected frees over several address windows",
			cnt_free_ok, cnt_bad);
		$display("Allocations: %0d local pops, %0d batch steals, %0d out of memory",
			cnt_local, cnt_steal, cnt_oom);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Timed out with %0d responses outstanding", pending_grants.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
